>>> rtl/cdq_pkg.sv
// cdq_pkg: shared types, constants and index helpers for the circular deque
// depends on nothing; used by circular_double_ended_queue
`timescale 1ns / 1ps

package cdq_pkg;

  // number of entries in the ring store
  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  typedef logic [IDX_W-1:0] idx_t;

  // operation codes on the kind port
  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_REAR  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_REAR   = 2'd3;

  // status codes on the status port
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  // index step forward with wrap
  function automatic idx_t idx_next(input idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

  // index step backward with wrap
  function automatic idx_t idx_prev(input idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - idx_t'(1));
  endfunction

endpackage

>>> rtl/cdq_ram.sv
// cdq_ram: generic single-write, single-read ram with registered read data
// standalone; instanced by circular_double_ended_queue for the ring store
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/circular_double_ended_queue.sv
// circular_double_ended_queue: fixed-depth deque over a ring store in ram
// depends on cdq_pkg and cdq_ram
`timescale 1ns / 1ps

// Usage
//   A command beat (kind, push_value) is taken on a rising edge where start
//   is high and busy is low. kind selects push front, push rear, pop front
//   or pop rear; push_value matters only on pushes.
//   Exactly one result beat follows: done is high for one cycle, in the
//   cycle right after the command edge, with pop_value, status, is_empty
//   and is_full valid in that cycle. The receiver cannot stall; a result
//   is gone after its cycle.
//   Busy is high while the result is shown, so the next command is taken
//   only after the result beat, since a pop waits for the registered read
//   of the ring store ram.
//   A push into a full deque is dropped with status overflow; a pop from an
//   empty deque returns zero with status underflow and changes nothing.
//   Reset (rst, synchronous) empties the deque and zeroes both indices;
//   the ram contents are not cleared and are read only after being written.

module circular_double_ended_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [31:0] push_value,
  output logic               done,
  output logic signed [31:0] pop_value,
  output logic [1:0]         status,
  output logic               is_empty,
  output logic               is_full
);

  cdq_pkg::state_t state, state_next;
  cdq_pkg::idx_t   head, head_next;
  cdq_pkg::idx_t   tail, tail_next;
  logic            empty, empty_next;

  logic [1:0] res_status, res_status_next;
  logic       res_empty, res_empty_next;
  logic       res_full, res_full_next;
  logic       res_pop, res_pop_next;

  logic                        accept;
  logic                        full_now;
  logic                        ram_we;
  cdq_pkg::idx_t               ram_waddr;
  cdq_pkg::idx_t               ram_raddr;
  logic [cdq_pkg::DATA_W-1:0]  ram_rdata;

  assign accept   = (state == cdq_pkg::ST_IDLE) && start;
  assign full_now = !empty && (head == cdq_pkg::idx_next(tail));

  // ring store
  cdq_ram #(
    .WIDTH (cdq_pkg::DATA_W),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (push_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // state and index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::ST_IDLE;
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_empty  <= res_empty_next;
    res_full   <= res_full_next;
    res_pop    <= res_pop_next;
  end

  // command decode, index update and ram access
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    empty_next      = empty;
    res_status_next = res_status;
    res_empty_next  = res_empty;
    res_full_next   = res_full;
    res_pop_next    = res_pop;
    ram_we          = 1'b0;
    ram_waddr       = head;
    ram_raddr       = (kind == cdq_pkg::KIND_POP_FRONT) ? head : tail;

    case (state)
      cdq_pkg::ST_IDLE: begin
        if (accept) begin
          state_next      = cdq_pkg::ST_RESP;
          res_status_next = cdq_pkg::STATUS_OK;
          res_pop_next    = 1'b0;
          if (kind == cdq_pkg::KIND_PUSH_FRONT || kind == cdq_pkg::KIND_PUSH_REAR) begin
            if (full_now) begin
              res_status_next = cdq_pkg::STATUS_OVERFLOW;
            end else begin
              ram_we = 1'b1;
              if (empty) begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
                ram_waddr  = '0;
              end else if (kind == cdq_pkg::KIND_PUSH_FRONT) begin
                head_next = cdq_pkg::idx_prev(head);
                ram_waddr = cdq_pkg::idx_prev(head);
              end else begin
                tail_next = cdq_pkg::idx_next(tail);
                ram_waddr = cdq_pkg::idx_next(tail);
              end
            end
          end else begin
            if (empty) begin
              res_status_next = cdq_pkg::STATUS_UNDERFLOW;
            end else begin
              res_pop_next = 1'b1;
              if (head == tail) begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b1;
              end else if (kind == cdq_pkg::KIND_POP_FRONT) begin
                head_next = cdq_pkg::idx_next(head);
              end else begin
                tail_next = cdq_pkg::idx_prev(tail);
              end
            end
          end
          res_empty_next = empty_next;
          res_full_next  = !empty_next && (head_next == cdq_pkg::idx_next(tail_next));
        end
      end
      cdq_pkg::ST_RESP: begin
        state_next = cdq_pkg::ST_IDLE;
      end
      default: begin
        state_next = cdq_pkg::ST_IDLE;
      end
    endcase
  end

  // result beat
  assign busy      = (state != cdq_pkg::ST_IDLE);
  assign done      = (state == cdq_pkg::ST_RESP);
  assign pop_value = res_pop ? $signed(ram_rdata) : 32'sd0;
  assign status    = res_status;
  assign is_empty  = res_empty;
  assign is_full   = res_full;

  // every result beat follows exactly one command beat
  a_done_after_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result beat without a command beat");

  a_cmd_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("command beat without a result beat");

  a_empty_idx_zero: assert property (@(posedge clk) disable iff (rst)
    empty |-> (head == '0 && tail == '0))
    else $error("empty deque with nonzero index");

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_empty && is_full))
    else $error("deque reported both empty and full");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != cdq_pkg::STATUS_OK) |-> (pop_value == 32'sd0))
    else $error("refused command returned a nonzero word");

endmodule

>>> dv/circular_double_ended_queue_tb.sv
// circular_double_ended_queue_tb: self-checking bench for the circular deque
// drives command beats, predicts each result beat and compares it field by field
// depends on cdq_pkg and circular_double_ended_queue
`timescale 1ns / 1ps

module circular_double_ended_queue_tb;

  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] word;
    bit                 hold;   // wait for all outstanding results first
  } cmd_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         code;
    logic               empty;
    logic               full;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         kind = cdq_pkg::KIND_PUSH_FRONT;
  logic signed [31:0] push_value = '0;
  logic               busy;
  logic               done;
  logic signed [31:0] pop_value;
  logic [1:0]         status;
  logic               is_empty;
  logic               is_full;

  cmd_t     cmd_q[$];
  outcome_t outcome_q[$];
  int       errors = 0;
  int       idle_left = 0;
  int       burst_left = 8;
  int       quiet_cycles = 0;

  // deque mirror
  logic signed [31:0] mirror_store [cdq_pkg::DEPTH];
  cdq_pkg::idx_t      mirror_head = '0;
  cdq_pkg::idx_t      mirror_tail = '0;
  logic               mirror_empty = 1'b1;

  circular_double_ended_queue dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .push_value (push_value),
    .done       (done),
    .pop_value  (pop_value),
    .status     (status),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  always #10 clk = ~clk;

  function automatic cdq_pkg::idx_t wrap_inc(input cdq_pkg::idx_t i);
    return (int'(i) == cdq_pkg::DEPTH - 1) ? cdq_pkg::idx_t'(0)
                                           : cdq_pkg::idx_t'(i + 1'b1);
  endfunction

  function automatic cdq_pkg::idx_t wrap_dec(input cdq_pkg::idx_t i);
    return (i == '0) ? cdq_pkg::idx_t'(cdq_pkg::DEPTH - 1) : cdq_pkg::idx_t'(i - 1'b1);
  endfunction

  function automatic logic mirror_full();
    return !mirror_empty && mirror_head == wrap_inc(mirror_tail);
  endfunction

  // apply one operation to the mirror and queue the result it should produce
  task automatic deque_apply(input logic [1:0] op, input logic signed [31:0] word);
    outcome_t      o;
    cdq_pkg::idx_t slot;
    o.value = '0;
    o.code  = cdq_pkg::STATUS_OK;
    if (op == cdq_pkg::KIND_PUSH_FRONT || op == cdq_pkg::KIND_PUSH_REAR) begin
      if (mirror_full()) begin
        o.code = cdq_pkg::STATUS_OVERFLOW;
      end else begin
        if (mirror_empty) begin
          mirror_head  = '0;
          mirror_tail  = '0;
          mirror_empty = 1'b0;
          slot = '0;
        end else if (op == cdq_pkg::KIND_PUSH_FRONT) begin
          mirror_head = wrap_dec(mirror_head);
          slot = mirror_head;
        end else begin
          mirror_tail = wrap_inc(mirror_tail);
          slot = mirror_tail;
        end
        mirror_store[slot] = word;
      end
    end else begin
      if (mirror_empty) begin
        o.code = cdq_pkg::STATUS_UNDERFLOW;
      end else begin
        slot = (op == cdq_pkg::KIND_POP_FRONT) ? mirror_head : mirror_tail;
        o.value = mirror_store[slot];
        if (mirror_head == mirror_tail) begin
          mirror_head  = '0;
          mirror_tail  = '0;
          mirror_empty = 1'b1;
        end else if (op == cdq_pkg::KIND_POP_FRONT) begin
          mirror_head = wrap_inc(mirror_head);
        end else begin
          mirror_tail = wrap_dec(mirror_tail);
        end
      end
    end
    o.empty = mirror_empty;
    o.full  = mirror_full();
    outcome_q.push_back(o);
  endtask

  task automatic add_cmd(input logic [1:0] op, input logic signed [31:0] word,
                         input bit hold);
    cmd_t c;
    c.op   = op;
    c.word = word;
    c.hold = hold;
    cmd_q.push_back(c);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $signed($urandom);
    endcase
  endfunction

  // driver: present command beats in bursts with random gaps
  always @(posedge clk) begin : drive
    bit   take;
    cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take)
        deque_apply(kind, push_value);
      if (!start || take) begin
        if (idle_left != 0) begin
          start <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (cmd_q.size() != 0 &&
                     !(cmd_q[0].hold && (take || outcome_q.size() != 0))) begin
          c = cmd_q.pop_front();
          start <= 1'b1;
          kind <= c.op;
          push_value <= c.word;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            idle_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every result beat checked against the oldest prediction
  always @(posedge clk) begin : watch
    outcome_t o;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result beat with none expected: pop_value %0d status %0d",
                 $time, pop_value, status);
        errors++;
      end else begin
        o = outcome_q.pop_front();
        if (pop_value !== o.value) begin
          $display("%0t: pop_value expected %0d actual %0d", $time, o.value, pop_value);
          errors++;
        end
        if (status !== o.code) begin
          $display("%0t: status expected %0d actual %0d", $time, o.code, status);
          errors++;
        end
        if (is_empty !== o.empty) begin
          $display("%0t: is_empty expected %0b actual %0b", $time, o.empty, is_empty);
          errors++;
        end
        if (is_full !== o.full) begin
          $display("%0t: is_full expected %0b actual %0b", $time, o.full, is_full);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("circular_double_ended_queue_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    int n;
    int plen;
    int mode;
    int push_pct;
    logic [1:0] op;

    // directed: underflow both ends, fill with wrap of the front index, overflow
    // both ends, drain from both ends to empty, underflow, then one push and pop
    add_cmd(cdq_pkg::KIND_POP_FRONT, 32'sh7fffffff, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_REAR, 32'sh80000000, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_FRONT, 32'sh7fffffff, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_FRONT, 32'sh80000000, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_REAR, -32'sd1, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_FRONT, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_REAR, 32'sh55555555, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_REAR, 32'shaaaaaaaa, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_FRONT, 32'sd1, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_REAR, -32'sd2, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_FRONT, 32'sd12345, 1'b1);
    add_cmd(cdq_pkg::KIND_PUSH_REAR, -32'sd12345, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_FRONT, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_REAR, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_REAR, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_FRONT, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_FRONT, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_REAR, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_FRONT, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_REAR, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_FRONT, 32'sd0, 1'b0);
    add_cmd(cdq_pkg::KIND_PUSH_REAR, 32'sd77, 1'b0);
    add_cmd(cdq_pkg::KIND_POP_REAR, 32'sd0, 1'b0);

    // random phases: fill-heavy, drain-heavy and balanced walks
    n = 0;
    while (n < 1700) begin
      mode = $urandom_range(0, 2);
      push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      plen = $urandom_range(10, 60);
      for (int i = 0; i < plen; i++) begin
        if ($urandom_range(1, 100) <= push_pct)
          op = $urandom_range(0, 1) ? cdq_pkg::KIND_PUSH_REAR : cdq_pkg::KIND_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? cdq_pkg::KIND_POP_REAR : cdq_pkg::KIND_POP_FRONT;
        add_cmd(op, pick_word(), (i == 0) && ($urandom_range(0, 2) == 0));
        n++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || start || outcome_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (errors == 0 && outcome_q.size() == 0) begin
      $display("circular_double_ended_queue_tb OK");
    end else begin
      $display("circular_double_ended_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> circular_double_ended_queue.f
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_double_ended_queue.sv
dv/circular_double_ended_queue_tb.sv
